@@ rtl/esbcc_pkg.sv @@
// ----------------------------------------------------------------------------
// esbcc_pkg
// Shared widths, reset values, register indexes and the sequencer states of
// the edge subset budget and connectivity check.
// ----------------------------------------------------------------------------
package esbcc_pkg;

	localparam int NODE_W        = 5;
	localparam int COST_W        = 4;
	localparam int SUM_W         = 10;
	localparam int LIMIT_W       = 10;
	localparam int CFG_IDX_W     = 1;
	localparam int DEF_MAX_NODES = 32;
	localparam int DEF_MAX_EDGES = 64;

	localparam logic [SUM_W-1:0]   SUM_MAX          = {SUM_W{1'b1}};
	localparam logic [LIMIT_W-1:0] SUBWAY_LIMIT_RST = LIMIT_W'(5);
	localparam logic [LIMIT_W-1:0] TRAM_LIMIT_RST   = LIMIT_W'(11);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUBWAY_LIMIT = 1'b0,
		REG_TRAM_LIMIT   = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SEED,
		ST_SEED_WAIT,
		ST_PASS,
		ST_DONE
	} state_t;

	// Saturating accumulate of one cost into a running total.
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
			input logic [COST_W-1:0] v);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + (SUM_W+1)'(v);
		sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

endpackage

@@ rtl/edge_subset_budget_connectivity_check.sv @@
// ----------------------------------------------------------------------------
// edge_subset_budget_connectivity_check
// Loads a candidate edge set, sums both costs of the selected edges and
// checks that the touched nodes form one connected group.
// ----------------------------------------------------------------------------
// Usage:
// Edges come in on the input channel (in_valid / in_stall), one request per
// cycle while the block is loading. Selected edges add to both cost totals,
// mark their nodes and go into an endpoint memory of MAX_EDGES entries.
// The request with last_edge set starts evaluation: in_stall stays high
// while a sequencer reads the stored edges back one per cycle and grows the
// reached-node set, pass after pass, until a pass changes nothing.
// Evaluation goes through a seed state and a seed wait state, then the
// passes (at most the number of touched nodes plus one), then the done
// state; with no stored edge it goes straight to done. Each result then
// sits in the output register (out_valid / out_stall) until taken; loading
// of the next set goes on meanwhile, but its result waits in the done
// state until the previous result is taken. The user is to write the
// limits through cfg_we / cfg_index / cfg_data only while idle; the block
// itself does not enforce this. Reset clears totals, node sets and the
// edge count and sets the limits (5 and 11); endpoint memory is not cleared.
// ----------------------------------------------------------------------------
module edge_subset_budget_connectivity_check #(
	parameter int MAX_NODES = esbcc_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES = esbcc_pkg::DEF_MAX_EDGES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [esbcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [esbcc_pkg::LIMIT_W-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [esbcc_pkg::NODE_W-1:0]    node_a,
	input  logic [esbcc_pkg::NODE_W-1:0]    node_b,
	input  logic                            selected,
	input  logic [esbcc_pkg::COST_W-1:0]    cost_subway,
	input  logic [esbcc_pkg::COST_W-1:0]    cost_tram,
	input  logic                            last_edge,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [esbcc_pkg::SUM_W-1:0]     total_subway,
	output logic [esbcc_pkg::SUM_W-1:0]     total_tram,
	output logic                            cost_ok,
	output logic                            connected,
	output logic                            accepted,
	output logic                            overflow
);
	import esbcc_pkg::*;

	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int MAP_DEPTH = 2 ** NODE_W;

	state_t state_q, state_d;

	logic [LIMIT_W-1:0]   subway_limit_q, tram_limit_q;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [CW-1:0]        rd_idx_q;
	logic [MAX_NODES-1:0] present_q, reached_q;
	logic [SUM_W-1:0]     sum_sub_q, sum_tram_q;
	logic                 ovf_q;
	logic                 changed_q;
	logic                 vld_s1;
	logic                 out_valid_q;

	logic [2*NW-1:0] edge_mem [MAX_EDGES];
	logic [2*NW-1:0] rd_data_s1;
	logic [EW-1:0]   rd_addr;
	logic            issue;
	logic            pass_end;

	logic [NW-1:0] node_map [MAP_DEPTH];
	logic [NW-1:0] a_mapped, b_mapped, ra, rb;
	logic          in_acc, store_en, fire;
	logic [SUM_W-1:0] res_sub_q, res_tram_q;
	logic             res_cost_ok_q, res_conn_q, res_ovf_q;
	logic             cost_ok_w, conn_w;

	// node number reduced modulo MAX_NODES, worked out at elaboration
	for (genvar i = 0; i < MAP_DEPTH; i++) begin : g_map
		localparam int MV = i % MAX_NODES;
		assign node_map[i] = NW'(MV);
	end

	assign a_mapped = node_map[node_a];
	assign b_mapped = node_map[node_b];
	assign ra       = rd_data_s1[2*NW-1:NW];
	assign rb       = rd_data_s1[NW-1:0];

	assign in_acc   = in_valid && !in_stall;
	assign store_en = in_acc && selected && (cnt_q < CW'(MAX_EDGES));
	assign cnt_d    = cnt_q + CW'(store_en);
	assign fire     = (state_q == ST_DONE) && !out_valid_q;
	assign pass_end = (state_q == ST_PASS) && !issue && !vld_s1;

	assign cost_ok_w = (sum_sub_q <= subway_limit_q) && (sum_tram_q <= tram_limit_q);
	assign conn_w    = &(~present_q | reached_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && last_edge)
					state_d = (cnt_d == '0) ? ST_DONE : ST_SEED;
			end
			ST_SEED:      state_d = ST_SEED_WAIT;
			ST_SEED_WAIT: state_d = ST_PASS;
			ST_PASS: begin
				if (pass_end && !changed_q)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q)
					state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		rd_addr  = '0;
		issue    = 1'b0;
		unique case (state_q)
			ST_LOAD: in_stall = 1'b0;
			ST_PASS: begin
				rd_addr = rd_idx_q[EW-1:0];
				issue   = rd_idx_q < cnt_q;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subway_limit_q <= SUBWAY_LIMIT_RST;
			tram_limit_q   <= TRAM_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SUBWAY_LIMIT: subway_limit_q <= cfg_data;
				REG_TRAM_LIMIT:   tram_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// endpoint store
	always_ff @(posedge clk) begin
		if (store_en)
			edge_mem[cnt_q[EW-1:0]] <= {a_mapped, b_mapped};
		rd_data_s1 <= edge_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			rd_idx_q   <= '0;
			present_q  <= '0;
			reached_q  <= '0;
			sum_sub_q  <= '0;
			sum_tram_q <= '0;
			ovf_q      <= 1'b0;
			changed_q  <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (in_acc && selected) begin
				sum_sub_q  <= sat_add(sum_sub_q, cost_subway);
				sum_tram_q <= sat_add(sum_tram_q, cost_tram);
				present_q  <= present_q | (MAX_NODES'(1) << a_mapped)
					| (MAX_NODES'(1) << b_mapped);
				cnt_q      <= cnt_d;
				if (!store_en)
					ovf_q <= 1'b1;
			end
			if (state_q == ST_SEED_WAIT) begin
				reached_q <= MAX_NODES'(1) << ra;
				rd_idx_q  <= '0;
				changed_q <= 1'b0;
			end
			if (issue)
				rd_idx_q <= rd_idx_q + CW'(1);
			// grow the reached set across an edge with one end reached
			if (state_q == ST_PASS && vld_s1 && (reached_q[ra] != reached_q[rb])) begin
				reached_q <= reached_q | (MAX_NODES'(1) << ra) | (MAX_NODES'(1) << rb);
				changed_q <= 1'b1;
			end
			// start another pass when the last one changed something
			if (pass_end && changed_q) begin
				rd_idx_q  <= '0;
				changed_q <= 1'b0;
			end
			if (fire) begin
				cnt_q      <= '0;
				present_q  <= '0;
				reached_q  <= '0;
				sum_sub_q  <= '0;
				sum_tram_q <= '0;
				ovf_q      <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_sub_q     <= sum_sub_q;
			res_tram_q    <= sum_tram_q;
			res_cost_ok_q <= cost_ok_w;
			res_conn_q    <= conn_w;
			res_ovf_q     <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign total_subway = res_sub_q;
	assign total_tram   = res_tram_q;
	assign cost_ok      = res_cost_ok_q;
	assign connected    = res_conn_q;
	assign accepted     = res_cost_ok_q && res_conn_q;
	assign overflow     = res_ovf_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_EDGES))
		else $error("stored edge count beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == CW'(MAX_EDGES)))
		else $error("overflow flagged while store not full");

	a_reached_present: assert property (@(posedge clk) disable iff (!arst_n)
		(reached_q & ~present_q) == '0)
		else $error("reached node that no selected edge touches");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

endmodule
